// File: sv/assert_macros.svh
// Assertion macros shared by the chunk planner modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge outside reset.
`define LCP_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Antecedent implies consequent in the same cycle.
`define LCP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Antecedent implies consequent in the next cycle.
`define LCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LCP_ASSERT(label, cond, msg)
`define LCP_ASSERT_IMP(label, ante, cons, msg)
`define LCP_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: sv/lcp_pkg.sv
// Types, constants and helpers of the CHS chunk planner.
package lcp_pkg;

    localparam logic [31:0] CHS_LIMIT = 32'd16450560;   // 1024 * 255 * 63
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 16;
    localparam int DIV_STAGES = 6;

    localparam logic [7:0] FUNC_READ  = 8'h02;
    localparam logic [7:0] FUNC_WRITE = 8'h03;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DISK_END = 3'd1;
    localparam logic [2:0] ST_CHS_LIM  = 3'd2;
    localparam logic [2:0] ST_BOUNCE   = 3'd3;
    localparam logic [2:0] ST_CYL      = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_SPT    = 3'd0;
    localparam logic [2:0] REG_HEADS  = 3'd1;
    localparam logic [2:0] REG_SIZE   = 3'd2;
    localparam logic [2:0] REG_DISK   = 3'd3;
    localparam logic [2:0] REG_BOUNCE = 3'd4;
    localparam logic [2:0] REG_DRIVE  = 3'd5;

    typedef struct packed {
        logic        action;
        logic [31:0] lba;
        logic [15:0] remaining;
        logic [19:0] buffer_address;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  chunk_count;
        logic [9:0]  cylinder;
        logic [7:0]  head;
        logic [5:0]  sector_number;
        logic [15:0] ax_word;
        logic [15:0] cx_word;
        logic [15:0] dx_word;
        logic [15:0] segment;
        logic [3:0]  offset;
        logic        used_bounce;
    } rsp_t;

    // geometry with the zero and overflow cases already folded in
    typedef struct packed {
        logic [5:0]  spt;
        logic [8:0]  heads;
        logic [12:0] size;
        logic [31:0] disk_sectors;
        logic [19:0] bounce_address;
        logic [7:0]  drive;
    } cfg_t;

    // classified request handed from front to back
    typedef struct packed {
        logic        action;
        logic [23:0] lba;
        logic [15:0] remaining;
        logic [19:0] addr;
        logic        bounce;
        logic        bounce_err;
        logic [2:0]  early_status;
    } qent_t;

    // true when a sector at addr runs over a 64KB page edge
    function automatic logic straddles(logic [19:0] addr, logic [12:0] size);
        logic [20:0] last;
        last = {1'b0, addr} + {8'b0, size} - 21'd1;
        return {1'b0, addr[19:16]} != last[20:16];
    endfunction

endpackage

// File: sv/lcp_div.sv
// Pipelined restoring divider, 24-bit dividend by 13-bit divisor, 4 bits a stage.
module lcp_div
    import lcp_pkg::*;
(
    input  logic        clk,
    input  logic [23:0] dividend,
    input  logic [12:0] divisor,
    output logic [23:0] quotient,
    output logic [12:0] remainder
);

    logic [12:0] r_reg [DIV_STAGES];
    logic [23:0] q_reg [DIV_STAGES];
    logic [23:0] n_reg [DIV_STAGES];
    logic [12:0] d_reg [DIV_STAGES];

    // four restoring steps: returns {remainder, quotient bits}
    function automatic logic [16:0] step4(logic [12:0] r_in, logic [3:0] b,
                                          logic [12:0] d);
        logic [12:0] r;
        logic [13:0] t;
        logic [3:0]  q;
        r = r_in;
        q = '0;
        for (int i = 3; i >= 0; i--)
        begin
            t = {r, b[i]};
            if (t >= {1'b0, d})
            begin
                r = 13'(t - {1'b0, d});
                q[i] = 1'b1;
            end
            else
            begin
                r = t[12:0];
            end
        end
        return {r, q};
    endfunction

    // stage registers
    always_ff @(posedge clk)
    begin
        logic [16:0] res;
        res = step4(13'd0, dividend[23:20], divisor);
        r_reg[0] <= res[16:4];
        q_reg[0] <= {20'b0, res[3:0]};
        n_reg[0] <= {dividend[19:0], 4'b0};
        d_reg[0] <= divisor;
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            res = step4(r_reg[k-1], n_reg[k-1][23:20], d_reg[k-1]);
            r_reg[k] <= res[16:4];
            q_reg[k] <= {q_reg[k-1][19:0], res[3:0]};
            n_reg[k] <= {n_reg[k-1][19:0], 4'b0};
            d_reg[k] <= d_reg[k-1];
        end
    end

    assign quotient  = q_reg[DIV_STAGES-1];
    assign remainder = r_reg[DIV_STAGES-1];

endmodule

// File: sv/lcp_front.sv
// Front end: takes requests, runs the range and page checks, queues them.
`include "assert_macros.svh"
module lcp_front
    import lcp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  push,
    input  req_t  req,
    output logic  full,
    output logic  q_valid,
    output qent_t q_ent,
    input  logic  q_take
);

    qent_t       mem_reg [MID_DEPTH];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [2:0]  count_reg, count_next;
    qent_t       ent;
    logic        accept, take, first_strad;

    assign accept = push && !full;
    assign take   = q_take && q_valid;

    // classification of the incoming request
    always_comb
    begin
        first_strad = straddles(req.buffer_address, cfg.size);
        ent.action = req.action;
        ent.lba = req.lba[23:0];
        ent.remaining = req.remaining;
        ent.bounce = first_strad;
        ent.addr = first_strad ? cfg.bounce_address : req.buffer_address;
        ent.bounce_err = first_strad && straddles(cfg.bounce_address, cfg.size);
        priority if (cfg.disk_sectors != 32'd0 && req.lba >= cfg.disk_sectors)
            ent.early_status = ST_DISK_END;
        else if (req.lba >= CHS_LIMIT)
            ent.early_status = ST_CHS_LIM;
        else
            ent.early_status = ST_OK;
    end

    // queue pointers
    always_comb
    begin
        wr_ptr_next = accept ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = take ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        count_next  = count_reg + {2'b0, accept} - {2'b0, take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            mem_reg[wr_ptr_reg] <= ent;
    end

    assign full    = count_reg == 3'(MID_DEPTH);
    assign q_valid = count_reg != 3'd0;
    assign q_ent   = mem_reg[rd_ptr_reg];

    `LCP_ASSERT(a_mid_bound, count_reg <= 3'(MID_DEPTH), "mid queue overfilled")
    `LCP_ASSERT_IMP(a_ptr_gap, count_reg == 3'd0, wr_ptr_reg == rd_ptr_reg,
                    "empty queue with pointer gap")
    `LCP_ASSERT_NEXT(a_fill, accept && !take && count_reg == 3'd0, q_valid,
                     "accepted request lost")

endmodule

// File: sv/lcp_back.sv
// Back end: divides out CHS, sizes the chunk, packs the words, buffers results.
`include "assert_macros.svh"
module lcp_back
    import lcp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  q_valid,
    input  qent_t q_ent,
    output logic  q_take,
    input  logic  pop,
    output logic  empty,
    output rsp_t  rsp
);

    // results in flight plus results held
    logic [4:0]  resv_reg, resv_next;
    logic        issue, deliver;

    logic        va_reg [DIV_STAGES];
    qent_t       ea_reg [DIV_STAGES];
    logic        vb_reg [DIV_STAGES];
    qent_t       eb_reg [DIV_STAGES];
    logic [5:0]  sb_reg [DIV_STAGES];
    logic [16:0] gb_reg [DIV_STAGES];

    logic [23:0] qa, qs, qb;
    logic [12:0] ra, rs, rb;

    rsp_t        res;
    qent_t       fe;
    logic [5:0]  s, cnt, cnt_r, cnt_b, sec;
    logic [23:0] cyl;
    logic [16:0] segrem;
    logic [9:0]  c10;
    logic [2:0]  st;

    rsp_t        mem_reg [OUT_DEPTH];
    logic [3:0]  wr_ptr_reg, rd_ptr_reg;
    logic [4:0]  count_reg, count_next;
    logic        wr;

    assign issue   = q_valid && resv_reg < 5'(OUT_DEPTH);
    assign q_take  = issue;
    assign deliver = pop && !empty;

    // lba / spt and the page room / sector size
    lcp_div u_div_a
    (
        .clk       (clk),
        .dividend  (q_ent.lba),
        .divisor   ({7'b0, cfg.spt}),
        .quotient  (qa),
        .remainder (ra)
    );

    lcp_div u_div_s
    (
        .clk       (clk),
        .dividend  (24'(17'h10000 - {1'b0, q_ent.addr[15:0]})),
        .divisor   (cfg.size),
        .quotient  (qs),
        .remainder (rs)
    );

    // track / heads
    lcp_div u_div_b
    (
        .clk       (clk),
        .dividend  (qa),
        .divisor   ({4'b0, cfg.heads}),
        .quotient  (qb),
        .remainder (rb)
    );

    // side payload aligned with the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                va_reg[k] <= 1'b0;
                vb_reg[k] <= 1'b0;
            end
        end
        else
        begin
            va_reg[0] <= issue;
            vb_reg[0] <= va_reg[DIV_STAGES-1];
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                va_reg[k] <= va_reg[k-1];
                vb_reg[k] <= vb_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ea_reg[0] <= q_ent;
        eb_reg[0] <= ea_reg[DIV_STAGES-1];
        sb_reg[0] <= ra[5:0];
        gb_reg[0] <= qs[16:0];
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            ea_reg[k] <= ea_reg[k-1];
            eb_reg[k] <= eb_reg[k-1];
            sb_reg[k] <= sb_reg[k-1];
            gb_reg[k] <= gb_reg[k-1];
        end
    end

    // final sizing and packing
    always_comb
    begin
        fe     = eb_reg[DIV_STAGES-1];
        s      = sb_reg[DIV_STAGES-1];
        segrem = gb_reg[DIV_STAGES-1];
        cyl    = qb;
        c10    = cyl[9:0];
        sec    = s + 6'd1;
        cnt    = cfg.spt - s;
        cnt_r  = (fe.remaining < {10'b0, cnt}) ? fe.remaining[5:0] : cnt;
        cnt_b  = fe.bounce ? {5'b0, |cnt_r} : cnt_r;
        if ({11'b0, cnt_b} > segrem)
            cnt_b = segrem[5:0];
        priority if (fe.early_status != ST_OK)
            st = fe.early_status;
        else if (cyl > 24'd1023)
            st = ST_CYL;
        else if (fe.bounce_err)
            st = ST_BOUNCE;
        else
            st = ST_OK;
        res = '0;
        res.status = st;
        if (st == ST_OK)
        begin
            res.chunk_count   = cnt_b;
            res.cylinder      = c10;
            res.head          = rb[7:0];
            res.sector_number = sec;
            res.ax_word       = {fe.action ? FUNC_WRITE : FUNC_READ, 2'b0, cnt_b};
            res.cx_word       = {c10[7:0], c10[9:8], sec};
            res.dx_word       = {rb[7:0], cfg.drive};
            res.segment       = fe.addr[19:4];
            res.offset        = fe.addr[3:0];
            res.used_bounce   = fe.bounce;
        end
    end

    assign wr = vb_reg[DIV_STAGES-1];

    // result queue and reservation count
    always_comb
    begin
        count_next = count_reg + {4'b0, wr} - {4'b0, deliver};
        resv_next  = resv_reg + {4'b0, issue} - {4'b0, deliver};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            resv_reg   <= '0;
        end
        else
        begin
            if (wr)
                wr_ptr_reg <= wr_ptr_reg + 4'd1;
            if (deliver)
                rd_ptr_reg <= rd_ptr_reg + 4'd1;
            count_reg <= count_next;
            resv_reg  <= resv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wr_ptr_reg] <= res;
    end

    assign empty = count_reg == 5'd0;
    assign rsp   = mem_reg[rd_ptr_reg];

    `LCP_ASSERT(a_resv_bound, resv_reg <= 5'(OUT_DEPTH), "reservations exceed queue")
    `LCP_ASSERT(a_held_le_resv, count_reg <= resv_reg, "held results exceed reservations")
    `LCP_ASSERT_IMP(a_wr_room, wr, count_reg < 5'(OUT_DEPTH), "result written to full queue")

endmodule

// File: sv/lba_to_chs_chunk_planner.sv
// Top level of the CHS transfer chunk planner.
// Plans one INT 13h style CHS chunk per request.
// Request side: queue style, a request is taken when push is high and full low.
// Result side: the oldest result sits on rsp while empty is low and leaves when
// pop is high; one result per request, in request order.
// Geometry and limits are written through cfg_we / cfg_index / cfg_data; the user
// must write them only while the block is idle, which the block does not enforce.
// Indexes outside the register list are ignored. The request path is a 4-entry
// front queue, two chained 6-stage pipelined dividers (LBA by sectors per
// track, then track by heads; the page room division runs beside the first)
// and a 16-entry result queue.
// Throughput: one request per cycle sustained while the result queue has room;
// the dividers take a new operand every cycle.
// Issue into the dividers is held back when in-flight plus held results fill
// the result queue, so a stalled receiver backs up to full, losing nothing.
// Reset clears both queues and restores the default geometry (63 sectors,
// 16 heads, 512-byte sectors, unknown size, drive 80h).
module lba_to_chs_chunk_planner
    import lcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  req_t        req,
    output logic        empty,
    input  logic        pop,
    output rsp_t        rsp,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [5:0]  spt_reg;
    logic [8:0]  heads_reg;
    logic [12:0] size_reg;
    logic [31:0] disk_reg;
    logic [19:0] bounce_reg;
    logic [7:0]  drive_reg;
    cfg_t        cfg;
    logic        q_valid, q_take;
    qent_t       q_ent;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spt_reg    <= 6'd63;
            heads_reg  <= 9'd16;
            size_reg   <= 13'd512;
            disk_reg   <= 32'd0;
            bounce_reg <= 20'd0;
            drive_reg  <= 8'd128;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SPT:    spt_reg    <= cfg_data[5:0];
                REG_HEADS:  heads_reg  <= cfg_data[8:0];
                REG_SIZE:   size_reg   <= cfg_data[12:0];
                REG_DISK:   disk_reg   <= cfg_data;
                REG_BOUNCE: bounce_reg <= cfg_data[19:0];
                REG_DRIVE:  drive_reg  <= cfg_data[7:0];
                default:    ;
            endcase
        end
    end

    // folded geometry
    always_comb
    begin
        cfg.spt = (spt_reg == 6'd0) ? 6'd1 : spt_reg;
        if (heads_reg == 9'd0)
            cfg.heads = 9'd1;
        else if (heads_reg > 9'd256)
            cfg.heads = 9'd256;
        else
            cfg.heads = heads_reg;
        cfg.size = (size_reg == 13'd0) ? 13'd1 : size_reg;
        cfg.disk_sectors = disk_reg;
        cfg.bounce_address = bounce_reg;
        cfg.drive = drive_reg;
    end

    lcp_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .push    (push),
        .req     (req),
        .full    (full),
        .q_valid (q_valid),
        .q_ent   (q_ent),
        .q_take  (q_take)
    );

    lcp_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_ent   (q_ent),
        .q_take  (q_take),
        .pop     (pop),
        .empty   (empty),
        .rsp     (rsp)
    );

endmodule

// File: bench/tb.sv
// Self-checking bench for the CHS chunk planner: directed table, then random requests.
module tb;
    import lcp_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE = 20;
    localparam int N_ROWS = 26;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    req_t        req = '0;
    logic        empty;
    logic        pop = 1'b0;
    rsp_t        rsp;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    lba_to_chs_chunk_planner dut (.*);

    // shadow geometry
    logic [5:0]  spt_reg;
    logic [8:0]  heads_reg;
    logic [12:0] size_reg;
    logic [31:0] disk_reg;
    logic [19:0] bounce_reg;
    logic [7:0]  drive_reg;

    rsp_t plans_due[$];
    int   taken = 0;
    int   errors = 0;
    int   cycles = 0;
    int   idle_in = 0;
    int   idle_out = 0;
    bit   typed_valid = 0;
    rsp_t typed_plan = '0;

    typedef struct {
        bit          is_cfg;
        logic [2:0]  idx;
        logic [31:0] data;
        req_t        r;
        bit          typed;
        logic [2:0]  st;
    } row_t;

    row_t steps [N_ROWS];

    always #2 clk = ~clk;

    // true when a sector at addr runs over a 64KB page edge
    function automatic bit crosses_page(logic [31:0] addr, logic [31:0] size);
        return (addr & 32'hFFFF0000) != ((addr + size - 32'd1) & 32'hFFFF0000);
    endfunction

    // expected chunk plan for one request
    function automatic rsp_t plan_chunk(req_t r);
        rsp_t        o;
        logic [31:0] spt, heads, size, s, t, h, c, cnt, addr, room;
        logic [31:0] sn;
        bit          bnc;
        o = '0;
        spt = (spt_reg != 0) ? spt_reg : 32'd1;
        heads = (heads_reg != 0) ? heads_reg : 32'd1;
        if (heads > 256) heads = 256;
        size = (size_reg != 0) ? size_reg : 32'd1;
        bnc = 0;
        if (disk_reg != 0 && r.lba >= disk_reg) begin
            o.status = ST_DISK_END;
            return o;
        end
        if (r.lba >= CHS_LIMIT) begin
            o.status = ST_CHS_LIM;
            return o;
        end
        s = r.lba % spt;
        t = r.lba / spt;
        h = t % heads;
        c = t / heads;
        if (c > 1023) begin
            o.status = ST_CYL;
            return o;
        end
        cnt = spt - s;
        if (cnt > r.remaining) cnt = r.remaining;
        addr = r.buffer_address;
        if (crosses_page(addr, size)) begin
            cnt = (cnt != 0) ? 32'd1 : 32'd0;
            bnc = 1;
            addr = bounce_reg;
            if (crosses_page(addr, size)) begin
                o.status = ST_BOUNCE;
                return o;
            end
        end
        room = (32'h10000 - (addr & 32'hFFFF)) / size;
        if (cnt > room) cnt = room;
        sn = s + 1;
        o.status = ST_OK;
        o.chunk_count = cnt[5:0];
        o.cylinder = c[9:0];
        o.head = h[7:0];
        o.sector_number = sn[5:0];
        o.ax_word = {(r.action ? FUNC_WRITE : FUNC_READ), cnt[7:0]};
        o.cx_word = {c[7:0], c[9:8], sn[5:0]};
        o.dx_word = {h[7:0], drive_reg};
        o.segment = addr[19:4];
        o.offset = addr[3:0];
        o.used_bounce = bnc;
        return o;
    endfunction

    // request side monitor: book the expected plan for every accepted request
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            plans_due.push_back(typed_valid ? typed_plan : plan_chunk(req));
            taken++;
        end
    end

    // result side monitor: compare with the oldest booked plan
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (plans_due.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("tb: result with none due: %p", rsp);
            end
            else
            begin
                rsp_t want;
                want = plans_due.pop_front();
                if (rsp !== want)
                begin
                    errors++;
                    if (errors <= 10) $display("tb: mismatch\n  exp %p\n  got %p", want, rsp);
                end
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
        pop <= ($urandom_range(0, 99) >= idle_out);

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic send_request(req_t r);
        int mark;
        while ($urandom_range(0, 99) < idle_in)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        req = r;
        push = 1'b1;
        mark = taken;
        do @(negedge clk); while (taken == mark);
        push = 1'b0;
    endtask

    // wait until every booked plan has come back, then let the pipe settle
    task automatic drain();
        push = 1'b0;
        while (plans_due.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_SPT:    spt_reg = data[5:0];
            REG_HEADS:  heads_reg = data[8:0];
            REG_SIZE:   size_reg = data[12:0];
            REG_DISK:   disk_reg = data;
            REG_BOUNCE: bounce_reg = data[19:0];
            REG_DRIVE:  drive_reg = data[7:0];
            default: ;
        endcase
    endtask

    // random geometry, extremes weighted in
    task automatic random_geometry();
        int k;
        k = $urandom_range(0, 9);
        write_reg(REG_SPT, (k < 2) ? 1 : (k < 4) ? 63 : (k == 4) ? 0 : $urandom_range(1, 63));
        k = $urandom_range(0, 9);
        write_reg(REG_HEADS, (k < 2) ? 1 : (k < 4) ? 256 : (k == 4) ? 0 :
                  (k == 5) ? $urandom_range(257, 511) : $urandom_range(1, 256));
        k = $urandom_range(0, 9);
        write_reg(REG_SIZE, (k < 3) ? 512 : (k < 5) ? 4096 : (k < 8) ?
                  (1 << $urandom_range(9, 12)) : (k == 8) ? 0 : $urandom_range(1, 8191));
        k = $urandom_range(0, 9);
        write_reg(REG_DISK, (k < 4) ? 0 : (k < 7) ? $urandom_range(1, 20000000) :
                  (k == 7) ? 32'hFFFFFFFF : $urandom);
        k = $urandom_range(0, 3);
        write_reg(REG_BOUNCE, (k == 0) ? {12'h0, 4'($urandom_range(0, 15)), 16'h0} :
                  (k == 1) ? 32'hFFFFF : $urandom & 32'hFFFFF);
        write_reg(REG_DRIVE, $urandom & 32'hFF);
    endtask

    function automatic req_t random_request();
        req_t        r;
        logic [31:0] spt, heads, span;
        int          k;
        spt = (spt_reg != 0) ? spt_reg : 32'd1;
        heads = (heads_reg != 0) ? heads_reg : 32'd1;
        if (heads > 256) heads = 256;
        span = spt * heads * 1024;
        r.action = 1'($urandom_range(0, 1));
        k = $urandom_range(0, 99);
        if (k < 60) r.lba = $urandom_range(0, span - 1);
        else if (k < 75) r.lba = span - $urandom_range(0, 3);
        else if (k < 85 && disk_reg != 0) r.lba = disk_reg - $urandom_range(0, 1);
        else r.lba = $urandom;
        k = $urandom_range(0, 99);
        r.remaining = (k < 5) ? 16'd0 : (k < 75) ? 16'($urandom_range(1, 80)) :
                      (k < 85) ? 16'hFFFF : 16'($urandom);
        if ($urandom_range(0, 1)) r.buffer_address = 20'($urandom);
        else r.buffer_address = {4'($urandom), 4'hF, 12'($urandom)};
        return r;
    endfunction

    initial
    begin
        steps = '{
            '{0, REG_SPT, 0, '{1'b0, 32'd0, 16'd1, 20'h00000}, 0, ST_OK},
            '{0, REG_SPT, 0, '{1'b1, 32'd0, 16'd0, 20'h12345}, 0, ST_OK},
            '{0, REG_SPT, 0, '{1'b0, 32'd62, 16'hFFFF, 20'hFFFFF}, 0, ST_OK},
            '{0, REG_SPT, 0, '{1'b1, 32'd1032191, 16'd63, 20'h0FE00}, 0, ST_OK},
            '{0, REG_SPT, 0, '{1'b0, 32'd1032192, 16'd1, 20'h0}, 1, ST_CYL},
            '{0, REG_SPT, 0, '{1'b0, CHS_LIMIT, 16'd1, 20'h0}, 1, ST_CHS_LIM},
            '{0, REG_SPT, 0, '{1'b1, 32'hFFFFFFFF, 16'hFFFF, 20'hFFFFF}, 1, ST_CHS_LIM},
            '{1, REG_DISK, 100, '0, 0, ST_OK},
            '{1, REG_BOUNCE, 32'h0FF00, '0, 0, ST_OK},
            '{1, REG_DRIVE, 0, '0, 0, ST_OK},
            '{0, REG_SPT, 0, '{1'b0, 32'd100, 16'd5, 20'h0}, 1, ST_DISK_END},
            '{0, REG_SPT, 0, '{1'b1, 32'd99, 16'd5, 20'h0}, 0, ST_OK},
            '{0, REG_SPT, 0, '{1'b0, 32'd5, 16'd5, 20'h1FFF0}, 1, ST_BOUNCE},
            '{1, REG_SPT, 0, '0, 0, ST_OK},
            '{1, REG_HEADS, 0, '0, 0, ST_OK},
            '{1, REG_SIZE, 0, '0, 0, ST_OK},
            '{1, REG_DISK, 0, '0, 0, ST_OK},
            '{0, REG_SPT, 0, '{1'b1, 32'd1023, 16'd7, 20'hFFFFF}, 0, ST_OK},
            '{1, REG_HEADS, 511, '0, 0, ST_OK},
            '{1, REG_SIZE, 3000, '0, 0, ST_OK},
            '{1, REG_SPT, 63, '0, 0, ST_OK},
            '{1, REG_DRIVE, 255, '0, 0, ST_OK},
            '{0, REG_SPT, 0, '{1'b0, CHS_LIMIT - 1, 16'hFFFF, 20'hF0000}, 0, ST_OK},
            '{0, REG_SPT, 0, '{1'b1, 32'd777777, 16'd2, 20'h3F500}, 0, ST_OK},
            '{1, REG_SIZE, 4096, '0, 0, ST_OK},
            '{0, REG_SPT, 0, '{1'b0, 32'd12345, 16'd40, 20'h7F000}, 0, ST_OK}
        };
        // defaults after reset
        spt_reg = 6'd63;
        heads_reg = 9'd16;
        size_reg = 13'd512;
        disk_reg = '0;
        bounce_reg = '0;
        drive_reg = 8'd128;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table
        foreach (steps[i])
        begin
            if (steps[i].is_cfg)
            begin
                drain();
                write_reg(steps[i].idx, steps[i].data);
            end
            else
            begin
                typed_valid = steps[i].typed;
                typed_plan = '0;
                typed_plan.status = steps[i].st;
                send_request(steps[i].r);
            end
        end
        typed_valid = 0;

        // random requests in three idling regimes; each drain is a full pause
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_in = (ph == 0) ? 17 : (ph == 1) ? 74 : 0;
            idle_out = (ph == 0) ? 74 : (ph == 1) ? 17 : 0;
            for (int blk = 0; blk < 5; blk++)
            begin
                drain();
                random_geometry();
                repeat (46) send_request(random_request());
            end
        end

        drain();
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/lcp_pkg.sv
sv/lcp_div.sv
sv/lcp_front.sv
sv/lcp_back.sv
sv/lba_to_chs_chunk_planner.sv
bench/tb.sv
